/* hw/rtl/b64d_pkg.sv */
`default_nettype none

package b64d_pkg;

    // Sextet codes beyond the 64 data values.
    localparam logic [6:0] SEXTET_PAD = 7'd64;
    localparam logic [6:0] SEXTET_BAD = 7'd65;

    localparam logic [7:0] CHAR_PAD     = 8'h3D;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;

    localparam logic [6:0] SEXTET_PLUS  = 7'd62;
    localparam logic [6:0] SEXTET_SLASH = 7'd63;

    // Results caused by one item: up to three entries, oldest in byte0.
    typedef struct packed {
        logic [1:0] cnt;
        logic       bv;
        logic       end_flag;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
    } bundle_t;

    // Decoder state seen by the top level.
    typedef struct packed {
        logic [1:0] phase;
        logic       halted;
        logic       held_valid;
    } status_t;

    // Maps one character to its sextet, or to the pad or invalid code.
    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] s;
        s = SEXTET_BAD;
        if (c >= 8'h41 && c <= 8'h5A) begin
            s = 7'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A) begin
            s = 7'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39) begin
            s = 7'(c - 8'h30 + 8'd52);
        end
        else if (c == CHAR_PLUS) begin
            s = SEXTET_PLUS;
        end
        else if (c == CHAR_SLASH) begin
            s = SEXTET_SLASH;
        end
        else if (c == CHAR_PAD) begin
            s = SEXTET_PAD;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/b64d_decode.sv */
`default_nettype none

module b64d_decode (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        text_char,
    input  wire logic              text_last,
    output b64d_pkg::bundle_t      bundle,
    output b64d_pkg::status_t      status
);

    logic [1:0]  phase_reg, phase_next;
    logic [17:0] accum_reg, accum_next;
    logic        halted_reg, halted_next;
    logic        held_v_reg, held_v_next;
    logic [7:0]  held_reg, held_next;
    logic [6:0]  sext;
    logic [1:0]  n;
    logic [7:0]  b0, b1, b2;

    assign sext = b64d_pkg::sextet_of(text_char);

    // One decode step for the character at the input.
    always_comb
    begin
        phase_next  = phase_reg;
        accum_next  = accum_reg;
        halted_next = halted_reg;
        held_v_next = held_v_reg;
        held_next   = held_reg;
        n  = 2'd0;
        b0 = 8'd0;
        b1 = 8'd0;
        b2 = 8'd0;
        if (held_v_reg) begin
            // Any character releases the byte held after "c0 c1 =".
            n           = 2'd1;
            b0          = held_reg;
            held_v_next = 1'b0;
            halted_next = 1'b1;
        end
        else if (!halted_reg) begin
            if (phase_reg == 2'd0 && text_char == b64d_pkg::CHAR_NEWLINE) begin
                // Newline between quads is skipped.
            end
            else if (sext == b64d_pkg::SEXTET_BAD) begin
                halted_next = 1'b1;
            end
            else if (sext == b64d_pkg::SEXTET_PAD) begin
                if (phase_reg == 2'd2) begin
                    held_next   = accum_reg[11:4];
                    held_v_next = 1'b1;
                end
                else if (phase_reg == 2'd3) begin
                    n           = 2'd2;
                    b0          = accum_reg[17:10];
                    b1          = accum_reg[9:2];
                    halted_next = 1'b1;
                end
                else begin
                    halted_next = 1'b1;
                end
            end
            else if (phase_reg == 2'd3) begin
                n          = 2'd3;
                b0         = accum_reg[17:10];
                b1         = accum_reg[9:2];
                b2         = {accum_reg[1:0], sext[5:0]};
                accum_next = 18'd0;
                phase_next = 2'd0;
            end
            else begin
                accum_next = {accum_reg[11:0], sext[5:0]};
                phase_next = phase_reg + 2'd1;
            end
        end

        // The last character closes the text and re-arms the decoder.
        if (text_last) begin
            phase_next  = 2'd0;
            accum_next  = 18'd0;
            halted_next = 1'b0;
            held_v_next = 1'b0;
            held_next   = 8'd0;
        end
    end

    // Results of this step; an empty last step gives one marker entry.
    always_comb
    begin
        bundle.byte0    = b0;
        bundle.byte1    = b1;
        bundle.byte2    = b2;
        bundle.end_flag = text_last;
        bundle.bv       = (n != 2'd0);
        if (text_last && n == 2'd0) begin
            bundle.cnt = 2'd1;
        end
        else begin
            bundle.cnt = n;
        end
    end

    // Phase, halt flag and held-byte flag, in the order of the status fields.
    assign status = {phase_reg, halted_reg, held_v_reg};

    // Decoder state advances once per accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= 2'd0;
            accum_reg  <= 18'd0;
            halted_reg <= 1'b0;
            held_v_reg <= 1'b0;
            held_reg   <= 8'd0;
        end
        else if (accept) begin
            phase_reg  <= phase_next;
            accum_reg  <= accum_next;
            halted_reg <= halted_next;
            held_v_reg <= held_v_next;
            held_reg   <= held_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/b64d_emit.sv */
`default_nettype none

module b64d_emit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire b64d_pkg::bundle_t bundle,
    output logic                   can_load,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             data_byte,
    output logic                   byte_valid,
    output logic                   text_end
);

    logic [1:0] cnt_reg;
    logic       bv_reg;
    logic       end_reg;
    logic [7:0] b0_reg, b1_reg, b2_reg;
    logic       take;

    assign out_valid  = (cnt_reg != 2'd0);
    assign take       = out_valid && out_ready;
    assign data_byte  = b0_reg;
    assign byte_valid = bv_reg;
    assign text_end   = end_reg && (cnt_reg == 2'd1);

    // A new bundle fits once the last waiting entry leaves this cycle.
    assign can_load = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && out_ready);

    // Entry count of the result buffer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 2'd0;
        end
        else if (load && bundle.cnt != 2'd0) begin
            cnt_reg <= bundle.cnt;
        end
        else if (take) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // Result bytes shift toward the output as entries are taken.
    always_ff @(posedge clk)
    begin
        if (load && bundle.cnt != 2'd0) begin
            bv_reg  <= bundle.bv;
            end_reg <= bundle.end_flag;
            b0_reg  <= bundle.byte0;
            b1_reg  <= bundle.byte1;
            b2_reg  <= bundle.byte2;
        end
        else if (take) begin
            b0_reg <= b1_reg;
            b1_reg <= b2_reg;
            b2_reg <= 8'd0;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/base64_stream_decoder_top.sv */
// Channel   Signals                                                 Direction
// input     in_valid, in_ready, text_char, text_last                into block
// output    out_valid, out_ready, data_byte, byte_valid, text_end   out of block
//
// Each character is decoded in the cycle it is accepted; its results appear
// one per cycle from the next cycle on, while out_ready is high.
// A character that completes a quad gives three results and so holds the
// input until its last result leaves: the result buffer is the limit on rate.
// Characters giving no result (not last) are taken every cycle in which it is empty.
// Reset clears the decoder state and empties the result buffer.
// A stalled output holds the current result and blocks input only once
// the buffer cannot take another character's results.
`default_nettype none

module base64_stream_decoder_top (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] text_char,
    input  wire logic       text_last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      data_byte,
    output logic            byte_valid,
    output logic            text_end
);

    b64d_pkg::bundle_t bundle;
    b64d_pkg::status_t status;
    logic              accept;
    logic              can_load;

    assign in_ready = can_load;
    assign accept   = in_valid && in_ready;

    // Character decode and quad state.
    b64d_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .text_char (text_char),
        .text_last (text_last),
        .bundle    (bundle),
        .status    (status)
    );

    // Result buffer and output serializer.
    b64d_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .bundle     (bundle),
        .can_load   (can_load),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_byte  (data_byte),
        .byte_valid (byte_valid),
        .text_end   (text_end)
    );

`ifndef SYNTHESIS
    // A held byte always sits after two sextets of a live quad.
    a_held_state: assert property (@(posedge clk) disable iff (!rst_n)
        status.held_valid |-> (!status.halted && status.phase == 2'd2))
        else $error("held byte with inconsistent quad state");

    // Input is only refused while results are waiting.
    a_ready_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input blocked with empty result buffer");

    // A result without a byte is only the end marker of a text.
    a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !byte_valid) |-> text_end)
        else $error("byteless result that does not end the text");
`endif

endmodule

`default_nettype wire
